FILE: rtl/jsb_pkg.sv
// Package for the binary Jacobi symbol unit.
// Holds the sequencer states, the symbol codes, the step flags and the mod-8 helper.
// Used by jsb_step and jacobi_symbol_binary.
package jsb_pkg;

  localparam int NUM_WIDTH_DEF = 64;
  localparam int MOD_WIDTH_DEF = 32;
  // Width of the modulus port.
  localparam int MOD_PORT_WIDTH = 31;

  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic zero;   // top value has reached zero
    logic flip;   // this step flips the sign
    logic swap;   // this step swapped the operands
  } step_flags_t;

  // The sign flips on a halving when the modulus is 3 or 5 mod 8.
  function automatic logic two_flip(input logic [2:0] m);
    return (m == 3'd3) || (m == 3'd5);
  endfunction

endpackage

FILE: rtl/jacobi_symbol_binary.sv
// Top level of the binary Jacobi symbol unit: sequencer and operand registers.
// Depends on jsb_pkg and jsb_step.
//
// A beat is taken when start is high and busy is low; busy then stays high until
// the result has been shown. The symbol appears on symbol_o for exactly one cycle
// with done_o high, and the receiver cannot stall it. A beat is loaded, then goes
// through the steps of the shared compare/subtract/shift unit until a is seen to
// reach zero, and then the result is presented. Each step either halves a, swaps
// a and p, or replaces a by (a - p) / 2, so the step count is data dependent; a
// modulus of 2 skips the loop and presents the Kronecker symbol straight after
// the load. The func_i selector is ignored.
module jacobi_symbol_binary #(
  parameter int NUM_WIDTH = jsb_pkg::NUM_WIDTH_DEF,
  parameter int MOD_WIDTH = jsb_pkg::MOD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [0:0]                          func_i,
  input  logic signed [NUM_WIDTH-1:0]         numerator_i,
  input  logic [jsb_pkg::MOD_PORT_WIDTH-1:0]  modulus_i,
  output logic                                done_o,
  output logic signed [1:0]                   symbol_o
);

  localparam int PW = (MOD_WIDTH < jsb_pkg::MOD_PORT_WIDTH) ? MOD_WIDTH
                                                             : jsb_pkg::MOD_PORT_WIDTH;
  localparam int AW = (NUM_WIDTH > PW) ? NUM_WIDTH : PW;

  jsb_pkg::state_e      state_q, state_d;
  logic [AW-1:0]        a_q, a_d;
  logic [PW-1:0]        p_q, p_d;
  logic                 t_neg_q, t_neg_d;
  logic                 neg_q, neg_d;
  logic                 swap_q, swap_d;
  logic [1:0]           sym_q, sym_d;

  logic [AW-1:0]        step_a;
  logic [PW-1:0]        step_p;
  jsb_pkg::step_flags_t step_flags;

  logic [PW-1:0]        p_in;
  logic [NUM_WIDTH-1:0] raw;
  logic [NUM_WIDTH-1:0] mag;
  logic                 accept;
  logic                 p_is_two;
  logic [1:0]           kron_sym;
  logic                 final_neg;

  assign accept   = start && (state_q == jsb_pkg::ST_IDLE);
  assign p_in     = modulus_i[PW-1:0];
  assign raw      = numerator_i;
  // Two's complement negate; the most negative value maps to its own magnitude.
  assign mag      = raw[NUM_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign p_is_two = (p_in == PW'(2));
  assign kron_sym = !raw[0] ? jsb_pkg::SYM_ZERO :
                    ((raw[2:0] == 3'd1) || (raw[2:0] == 3'd7)) ? jsb_pkg::SYM_POS
                                                               : jsb_pkg::SYM_NEG;
  assign final_neg = t_neg_q ^ neg_q;

  jsb_step #(
    .AW (AW),
    .PW (PW)
  ) u_step (
    .a_i         (a_q),
    .p_i         (p_q),
    .swap_pend_i (swap_q),
    .a_o         (step_a),
    .p_o         (step_p),
    .flags_o     (step_flags)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      jsb_pkg::ST_IDLE: begin
        if (start) begin
          state_d = p_is_two ? jsb_pkg::ST_DONE : jsb_pkg::ST_RUN;
        end
      end
      jsb_pkg::ST_RUN: begin
        if (step_flags.zero) begin
          state_d = jsb_pkg::ST_DONE;
        end
      end
      jsb_pkg::ST_DONE: begin
        state_d = jsb_pkg::ST_IDLE;
      end
      default: begin
        state_d = jsb_pkg::ST_IDLE;
      end
    endcase
  end

  // Operand and sign registers.
  always_comb begin
    a_d     = a_q;
    p_d     = p_q;
    t_neg_d = t_neg_q;
    neg_d   = neg_q;
    swap_d  = swap_q;
    sym_d   = sym_q;
    if (accept) begin
      a_d     = AW'(mag);
      p_d     = p_in;
      t_neg_d = 1'b0;
      neg_d   = raw[NUM_WIDTH-1] && (p_in[1:0] == 2'b11);
      swap_d  = 1'b0;
      sym_d   = kron_sym;
    end else if (state_q == jsb_pkg::ST_RUN) begin
      if (step_flags.zero) begin
        if (p_q == PW'(1)) begin
          sym_d = final_neg ? jsb_pkg::SYM_NEG : jsb_pkg::SYM_POS;
        end else begin
          sym_d = jsb_pkg::SYM_ZERO;
        end
      end else begin
        a_d     = step_a;
        p_d     = step_p;
        t_neg_d = t_neg_q ^ step_flags.flip;
        swap_d  = step_flags.swap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    p_q     <= p_d;
    t_neg_q <= t_neg_d;
    neg_q   <= neg_d;
    swap_q  <= swap_d;
    sym_q   <= sym_d;
  end

  assign busy     = (state_q != jsb_pkg::ST_IDLE);
  assign done_o   = (state_q == jsb_pkg::ST_DONE);
  assign symbol_o = sym_q;

endmodule

FILE: rtl/jsb_step.sv
// Shared step unit of the binary Jacobi symbol loop: one compare, one subtract
// and one shift, selected by a pending swap, the parity of a and the a < p compare.
// Depends on jsb_pkg.
module jsb_step #(
  parameter int AW = 64,
  parameter int PW = 31
) (
  input  logic [AW-1:0]           a_i,
  input  logic [PW-1:0]           p_i,
  input  logic                    swap_pend_i,
  output logic [AW-1:0]           a_o,
  output logic [PW-1:0]           p_o,
  output jsb_pkg::step_flags_t    flags_o
);

  logic [AW-1:0] p_ext;
  logic [AW-1:0] diff;
  logic          lt;
  logic          p_flip;

  assign p_ext  = {{(AW-PW){1'b0}}, p_i};
  assign lt     = a_i < p_ext;
  assign diff   = a_i - p_ext;
  assign p_flip = jsb_pkg::two_flip(p_i[2:0]);

  always_comb begin
    a_o          = a_i;
    p_o          = p_i;
    flags_o.zero = (a_i == '0);
    flags_o.flip = 1'b0;
    flags_o.swap = 1'b0;
    // Right after a swap the subtract runs at once, even when a is even.
    if (swap_pend_i || (a_i[0] && !lt)) begin
      a_o          = {1'b0, diff[AW-1:1]};
      flags_o.flip = p_flip;
    end else if (!a_i[0]) begin
      a_o          = {1'b0, a_i[AW-1:1]};
      flags_o.flip = p_flip;
    end else begin
      // a is odd and below p, so it fits in the modulus width.
      a_o          = p_ext;
      p_o          = a_i[PW-1:0];
      flags_o.flip = (a_i[1:0] == 2'b11) && (p_i[1:0] == 2'b11);
      flags_o.swap = 1'b1;
    end
  end

endmodule

FILE: dv/tb_jacobi_symbol_binary.sv
// Testbench for jacobi_symbol_binary: directed edge cases, then random prime and mixed moduli.
// Predicts each symbol with a local binary Jacobi loop and checks every done_o beat in order.
// Depends on jsb_pkg and the jacobi_symbol_binary RTL.
module tb_jacobi_symbol_binary;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MW = jsb_pkg::MOD_PORT_WIDTH;

  typedef struct {
    logic [63:0]       num;
    logic [MW-1:0]     modl;
    logic signed [1:0] sym;
  } symbol_expect_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [0:0]                func_i = 1'b0;
  logic signed [63:0]        numerator_i = '0;
  logic [MW-1:0]             modulus_i = '0;
  logic                      done_o;
  logic signed [1:0]         symbol_o;

  symbol_expect_t pending_symbols[$];
  int unsigned    fail_count = 0;
  bit             gaps_enabled = 1'b1;

  jacobi_symbol_binary u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .numerator_i (numerator_i),
    .modulus_i   (modulus_i),
    .done_o      (done_o),
    .symbol_o    (symbol_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit halving_flips(input logic [63:0] m);
    return (m[2:0] == 3'd3) || (m[2:0] == 3'd5);
  endfunction

  // Binary Jacobi loop with the Kronecker rule for a modulus of two.
  function automatic logic signed [1:0] jacobi_symbol(input logic [63:0] num,
                                                      input logic [MW-1:0] modl);
    logic [63:0] a;
    logic [63:0] p;
    logic [63:0] held;
    bit          negative;
    bit          flipped;
    negative = 1'b0;
    flipped  = 1'b0;
    p = 64'(modl);
    if (p == 64'd2) begin
      if (!num[0]) begin
        return jsb_pkg::SYM_ZERO;
      end
      return (num[2:0] == 3'd1 || num[2:0] == 3'd7) ? jsb_pkg::SYM_POS : jsb_pkg::SYM_NEG;
    end
    // Negating the most negative value leaves 2^63, which is its true magnitude.
    if (num[63]) begin
      negative = (p[1:0] == 2'b11);
      a = 64'd0 - num;
    end else begin
      a = num;
    end
    while (a != 64'd0) begin
      while (!a[0]) begin
        a = a >> 1;
        if (halving_flips(p)) flipped = ~flipped;
      end
      if (a < p) begin
        held = a;
        a = p;
        p = held;
        if (a[1:0] == 2'b11 && p[1:0] == 2'b11) flipped = ~flipped;
      end
      a = (a - p) >> 1;
      if (halving_flips(p)) flipped = ~flipped;
    end
    if (negative) flipped = ~flipped;
    if (p != 64'd1) begin
      return jsb_pkg::SYM_ZERO;
    end
    return flipped ? jsb_pkg::SYM_NEG : jsb_pkg::SYM_POS;
  endfunction

  function automatic bit prime_trial(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n % 2 == 0) return n == 2;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [MW-1:0] random_odd_prime();
    int unsigned     bits;
    longint unsigned cand;
    // Most primes stay small so the trial division remains cheap.
    bits = ($urandom_range(99) < 70) ? $urandom_range(2, 20) : $urandom_range(21, 31);
    do begin
      cand = (longint'($urandom) | (64'd1 << (bits - 1)) | 64'd1) & ((64'd1 << bits) - 1);
    end while (!prime_trial(cand));
    return MW'(cand);
  endfunction

  function automatic logic [63:0] random_numerator(input logic [MW-1:0] modl);
    logic [63:0] mag;
    if ($urandom_range(99) < 10) begin
      mag = 64'(modl) * 64'($urandom_range(0, 1000));
    end else begin
      mag = {$urandom, $urandom} >> $urandom_range(0, 63);
    end
    return $urandom_range(1) ? 64'd0 - mag : mag;
  endfunction

  // Drives one beat and returns right after the edge that accepts it.
  task automatic send_item(input logic fn, input logic [63:0] num,
                           input logic [MW-1:0] modl);
    symbol_expect_t entry;
    if (gaps_enabled && $urandom_range(99) < 20) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 199)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       = 1'b1;
    func_i      = fn;
    numerator_i = num;
    modulus_i   = modl;
    do begin
      @(posedge clk_i);
    end while (busy);
    entry.num  = num;
    entry.modl = modl;
    entry.sym  = jacobi_symbol(num, modl);
    pending_symbols.push_back(entry);
  endtask

  task automatic test_special_cases();
    send_item(1'b0, 64'd0, 31'd1);
    send_item(1'b0, 64'd0, 31'd3);
    send_item(1'b0, 64'd5, 31'd0);
    send_item(1'b0, 64'd7, 31'd12);
    send_item(1'b0, 64'd123456789, 31'h4000_0000);
    send_item(1'b1, 64'd2, 31'd7);
    send_item(1'b0, 64'h8000_0000_0000_0000, 31'd3);
    send_item(1'b0, 64'h8000_0000_0000_0000, 31'd7);
    send_item(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    send_item(1'b0, 64'h8000_0000_0000_0001, 31'h7FFF_FFFF);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 31'd3);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 31'd5);
    send_item(1'b0, 64'd10, 31'd5);
    send_item(1'b0, 64'hDEAD_BEEF_0123_4567, 31'd1);
  endtask

  task automatic test_modulus_two();
    for (int i = 0; i < 8; i++) begin
      send_item(1'b0, 64'(i), 31'd2);
    end
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFD, 31'd2);
  endtask

  task automatic test_random_prime_moduli(input int unsigned count);
    logic [MW-1:0] modl;
    for (int unsigned i = 0; i < count; i++) begin
      // One long stretch runs back to back.
      gaps_enabled = !(i >= 150 && i < 350);
      modl = random_odd_prime();
      send_item(1'($urandom_range(1)), random_numerator(modl), modl);
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_any_moduli(input int unsigned count);
    logic [MW-1:0] modl;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0:       modl = MW'($urandom_range(0, 2));
        1:       modl = MW'($urandom_range(0, 64));
        2:       modl = MW'($urandom) | 31'd1;
        default: modl = MW'($urandom);
      endcase
      send_item(1'($urandom_range(1)), random_numerator(modl), modl);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_symbols.size() == 0) begin
        $error("symbol beat with nothing pending: actual %0d", symbol_o);
        fail_count++;
      end else begin
        if (symbol_o !== pending_symbols[0].sym) begin
          $error("symbol mismatch: expected %0d, actual %0d (numerator %h, modulus %0d)",
                 pending_symbols[0].sym, symbol_o, pending_symbols[0].num,
                 pending_symbols[0].modl);
          fail_count++;
        end
        void'(pending_symbols.pop_front());
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_special_cases();
    test_modulus_two();
    test_random_prime_moduli(500);
    test_random_any_moduli(330);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
